@@ rtl/fkr_pkg.sv @@
// Package for the five-way key repeat cursor block: widths, codes and move helpers.
package fkr_pkg;

  localparam int TIME_W    = 32;
  localparam int POS_W     = 10;
  localparam int STEP_W    = 8;
  localparam int DLY_W     = 16;
  localparam int BTN_COUNT = 5;
  localparam int DIR_COUNT = 4;

  // button bit positions
  localparam int BTN_UP     = 0;
  localparam int BTN_DOWN   = 1;
  localparam int BTN_LEFT   = 2;
  localparam int BTN_RIGHT  = 3;
  localparam int BTN_CENTRE = 4;

  // configuration register indexes
  localparam logic [2:0] CFG_REPEAT_DELAY = 3'd0;
  localparam logic [2:0] CFG_REPEAT_RATE  = 3'd1;
  localparam logic [2:0] CFG_STEP_SIZE    = 3'd2;
  localparam logic [2:0] CFG_X_LIMIT      = 3'd3;
  localparam logic [2:0] CFG_Y_LIMIT      = 3'd4;

  localparam logic [DLY_W-1:0]  RST_REPEAT_DELAY = 16'd400;
  localparam logic [DLY_W-1:0]  RST_REPEAT_RATE  = 16'd80;
  localparam logic [STEP_W-1:0] RST_STEP_SIZE    = 8'd10;
  localparam logic [POS_W-1:0]  RST_X_LIMIT      = 10'd471;
  localparam logic [POS_W-1:0]  RST_Y_LIMIT      = 10'd303;

  localparam logic [1:0] LAMP_LAST = 2'd2;

  typedef logic [POS_W-1:0] pos_t;

  // move toward zero, clamped at zero
  function automatic pos_t move_dec(input pos_t pos, input logic [STEP_W-1:0] step);
    logic [POS_W:0] ext_step;
    ext_step = {{(POS_W + 1 - STEP_W){1'b0}}, step};
    if ({1'b0, pos} < ext_step) begin
      move_dec = '0;
    end else begin
      move_dec = pos - POS_W'(step);
    end
  endfunction

  // move toward the limit, clamped at the limit
  function automatic pos_t move_inc(input pos_t pos, input logic [STEP_W-1:0] step,
                                    input pos_t lim);
    logic [POS_W:0] sum;
    sum = {1'b0, pos} + {{(POS_W + 1 - STEP_W){1'b0}}, step};
    if (sum > {1'b0, lim}) begin
      move_inc = lim;
    end else begin
      move_inc = sum[POS_W-1:0];
    end
  endfunction

  function automatic logic [1:0] lamp_adv(input logic [1:0] lamp, input logic en);
    if (!en) begin
      lamp_adv = lamp;
    end else if (lamp >= LAMP_LAST) begin
      lamp_adv = 2'd0;
    end else begin
      lamp_adv = lamp + 2'd1;
    end
  endfunction

endpackage

@@ rtl/five_way_key_repeat_cursor.sv @@
// Top level: five-way button poller with auto-repeat cursor and lamp mode control.
//
// One poll request (five active-low button levels and a millisecond timestamp) is taken
// per clock and gives one result: the poll is held in an input register, then
// the whole update (edge detect, held/repeat time compares, the up-down and left-right
// move chains, lamp advance, centre toggle) is done in one pass into the result register.
// Sustained rate is one poll per cycle while the result side keeps taking; a stalled
// result holds the input register, and the block then stops taking polls. Configuration
// writes are always taken and should only be made while no poll is in flight.
module five_way_key_repeat_cursor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [4:0]                    in_button_levels,
  input  logic [31:0]                   in_time_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fkr_pkg::POS_W-1:0]     out_cursor_x_out,
  output logic [fkr_pkg::POS_W-1:0]     out_cursor_y_out,
  output logic                          out_cursor_mode_out,
  output logic [1:0]                    out_lamp_mode_out,
  output logic                          out_abort_request,
  output logic                          out_cursor_moved,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [15:0]                   cfg_data
);
  import fkr_pkg::*;

  // configuration
  logic [DLY_W-1:0]  delay_r;
  logic [DLY_W-1:0]  rate_r;
  logic [STEP_W-1:0] step_r;
  pos_t              xlim_r;
  pos_t              ylim_r;

  // input register
  logic              in_vld_r;
  logic [4:0]        lev_in_r;
  logic [TIME_W-1:0] now_r;

  // block state
  logic [4:0]        prev_lev_r;
  logic [TIME_W-1:0] press_t_r [DIR_COUNT];
  logic [TIME_W-1:0] rep_t_r   [DIR_COUNT];
  pos_t              cx_r;
  pos_t              cy_r;
  logic              mode_r;
  logic [1:0]        lamp_r;

  // result register
  logic              out_vld_r;
  pos_t              ox_r;
  pos_t              oy_r;
  logic              omode_r;
  logic [1:0]        olamp_r;
  logic              oabort_r;
  logic              omoved_r;

  logic              advance;
  logic              fire;
  logic [4:0]        press;
  logic [DIR_COUNT-1:0] rep;
  logic [DIR_COUNT-1:0] act;
  pos_t              y_a, y_b, x_a, x_b;
  pos_t              cx_nxt, cy_nxt;
  logic              mode_nxt;
  logic [1:0]        lamp_a, lamp_b, lamp_c, lamp_nxt;
  logic              moved_nxt;

  assign cfg_ready = 1'b1;
  assign advance   = !out_vld_r || out_ready;
  assign in_ready  = !in_vld_r || advance;
  assign fire      = in_vld_r && advance;

  // edges on all buttons and repeat qualification on the four directions, in parallel
  always_comb begin
    press = prev_lev_r & ~lev_in_r;
    for (int i = 0; i < DIR_COUNT; i++) begin
      rep[i] = prev_lev_r[i] == 1'b0 && lev_in_r[i] == 1'b0 &&
               (now_r - press_t_r[i]) >= TIME_W'(delay_r) &&
               (now_r - rep_t_r[i]) >= TIME_W'(rate_r);
      act[i] = mode_r && (press[i] || rep[i]);
    end
  end

  // up then down on y, left then right on x; centre applied last
  always_comb begin
    y_a = act[BTN_UP]    ? move_dec(cy_r, step_r) : cy_r;
    y_b = act[BTN_DOWN]  ? move_inc(y_a, step_r, ylim_r) : y_a;
    x_a = act[BTN_LEFT]  ? move_dec(cx_r, step_r) : cx_r;
    x_b = act[BTN_RIGHT] ? move_inc(x_a, step_r, xlim_r) : x_a;

    lamp_a   = lamp_adv(lamp_r, !mode_r && press[BTN_UP]);
    lamp_b   = lamp_adv(lamp_a, !mode_r && press[BTN_DOWN]);
    lamp_c   = lamp_adv(lamp_b, !mode_r && press[BTN_LEFT]);
    lamp_nxt = lamp_adv(lamp_c, !mode_r && press[BTN_RIGHT]);

    mode_nxt = mode_r ^ press[BTN_CENTRE];
    if (press[BTN_CENTRE] && !mode_r) begin
      cx_nxt = xlim_r >> 1;
      cy_nxt = ylim_r >> 1;
    end else begin
      cx_nxt = x_b;
      cy_nxt = y_b;
    end
    moved_nxt = (cx_nxt != cx_r) || (cy_nxt != cy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= RST_REPEAT_DELAY;
      rate_r  <= RST_REPEAT_RATE;
      step_r  <= RST_STEP_SIZE;
      xlim_r  <= RST_X_LIMIT;
      ylim_r  <= RST_Y_LIMIT;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_REPEAT_DELAY: delay_r <= cfg_data;
        CFG_REPEAT_RATE:  rate_r  <= cfg_data;
        CFG_STEP_SIZE:    step_r  <= cfg_data[STEP_W-1:0];
        CFG_X_LIMIT:      xlim_r  <= cfg_data[POS_W-1:0];
        CFG_Y_LIMIT:      ylim_r  <= cfg_data[POS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      lev_in_r <= in_button_levels;
      now_r    <= TIME_W'(in_time_ms);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_lev_r <= '1;
      cx_r       <= '0;
      cy_r       <= '0;
      mode_r     <= 1'b0;
      lamp_r     <= 2'd0;
      for (int i = 0; i < DIR_COUNT; i++) begin
        press_t_r[i] <= '0;
        rep_t_r[i]   <= '0;
      end
    end else if (fire) begin
      prev_lev_r <= lev_in_r;
      cx_r       <= cx_nxt;
      cy_r       <= cy_nxt;
      mode_r     <= mode_nxt;
      lamp_r     <= lamp_nxt;
      for (int i = 0; i < DIR_COUNT; i++) begin
        if (press[i]) begin
          press_t_r[i] <= now_r;
        end
        if (press[i] || act[i]) begin
          rep_t_r[i] <= now_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
    if (fire) begin
      ox_r     <= cx_nxt;
      oy_r     <= cy_nxt;
      omode_r  <= mode_nxt;
      olamp_r  <= lamp_nxt;
      oabort_r <= press[BTN_CENTRE];
      omoved_r <= moved_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_cursor_x_out    = ox_r;
  assign out_cursor_y_out    = oy_r;
  assign out_cursor_mode_out = omode_r;
  assign out_lamp_mode_out   = olamp_r;
  assign out_abort_request   = oabort_r;
  assign out_cursor_moved    = omoved_r;

`ifndef NO_ASSERTIONS
  // a request in the input register always reaches the result register
  a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("processed request did not reach result register");

  // lamp mode only changes while in normal mode
  a_lamp_normal: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (lamp_nxt != lamp_r) |-> !mode_r)
    else $error("lamp mode changed in cursor mode");

  // in normal mode without a centre press the cursor stays put
  a_no_move_normal: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !mode_r && !press[BTN_CENTRE] |=> !omoved_r)
    else $error("cursor moved in normal mode");

  // lamp state never leaves its three codes
  a_lamp_range: assert property (@(posedge clk) disable iff (!rst_n)
    lamp_r != 2'd3)
    else $error("lamp mode out of range");
`endif

endmodule
